>>> src/rgb_frame_effect_engine_unit_defines.svh
// ----------------------------------------------------------------------------
// rgb frame effect engine assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef RGB_FRAME_EFFECT_ENGINE_UNIT_DEFINES_SVH
`define RGB_FRAME_EFFECT_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication
`define RFE_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgb frame effect engine check failed");

// next-cycle implication
`define RFE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgb frame effect engine check failed");

`endif

>>> src/rfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfe_pkg
// types, codes and the per-pixel point operation of the frame effect engine
// ----------------------------------------------------------------------------
package rfe_pkg;

   localparam int MAX_COLS_DEF = 64;
   localparam int MAX_ROWS_DEF = 64;

   localparam int KIND_W    = 2;
   localparam int COORD_W   = 6;
   localparam int CH_W      = 8;
   localparam int PIX_W     = 3 * CH_W;
   localparam int CODE_W    = 4;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 1;

   localparam logic [CH_W-1:0] CH_MAX       = 8'd255;
   localparam logic [CH_W-1:0] CONTRAST_MID = 8'(255 / 2);

   // sum / 3 == (sum * 683) >> 11 for sums up to 765
   localparam int GRAY_MUL   = 683;
   localparam int GRAY_SHIFT = 11;
   localparam int SUM_W      = CH_W + 2;
   localparam int PROD_W     = 2 * SUM_W;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_COLUMNS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_ROWS    = 1'd1;

   localparam logic [CODE_W-1:0] EFF_GRAY     = 4'd0;
   localparam logic [CODE_W-1:0] EFF_NEG_R    = 4'd1;
   localparam logic [CODE_W-1:0] EFF_NEG_G    = 4'd2;
   localparam logic [CODE_W-1:0] EFF_NEG_B    = 4'd3;
   localparam logic [CODE_W-1:0] EFF_HFLIP    = 4'd4;
   localparam logic [CODE_W-1:0] EFF_VFLIP    = 4'd5;
   localparam logic [CODE_W-1:0] EFF_ZERO_R   = 4'd6;
   localparam logic [CODE_W-1:0] EFF_ZERO_G   = 4'd7;
   localparam logic [CODE_W-1:0] EFF_ZERO_B   = 4'd8;
   localparam logic [CODE_W-1:0] EFF_CONTRAST = 4'd9;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_APPLY = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PT_RD,
      ST_PT_WR,
      ST_SW_RDA,
      ST_SW_RDB,
      ST_SW_WA,
      ST_SW_WB
   } state_type;

   function automatic logic [CH_W-1:0] threshold(input logic [CH_W-1:0] v);
      return (v > CONTRAST_MID) ? CH_MAX : '0;
   endfunction

   function automatic logic [PIX_W-1:0] point_op(input logic [PIX_W-1:0] px,
                                                 input logic [CODE_W-1:0] code);
      logic [CH_W-1:0]   r;
      logic [CH_W-1:0]   g;
      logic [CH_W-1:0]   b;
      logic [SUM_W-1:0]  sum;
      logic [PROD_W-1:0] prod;
      r    = px[2*CH_W +: CH_W];
      g    = px[CH_W +: CH_W];
      b    = px[0 +: CH_W];
      sum  = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
      prod = PROD_W'(sum) * PROD_W'(GRAY_MUL);
      unique case (code)
         EFF_GRAY: begin
            r = prod[GRAY_SHIFT +: CH_W];
            g = prod[GRAY_SHIFT +: CH_W];
            b = prod[GRAY_SHIFT +: CH_W];
         end
         EFF_NEG_R:  r = CH_MAX - r;
         EFF_NEG_G:  g = CH_MAX - g;
         EFF_NEG_B:  b = CH_MAX - b;
         EFF_ZERO_R: r = '0;
         EFF_ZERO_G: g = '0;
         EFF_ZERO_B: b = '0;
         EFF_CONTRAST: begin
            r = threshold(r);
            g = threshold(g);
            b = threshold(b);
         end
         default: ;
      endcase
      return {r, g, b};
   endfunction

endpackage

>>> src/rfe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfe_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rfe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/rgb_frame_effect_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_frame_effect_engine_unit
// rgb frame store with pixel write/read and in-place point ops and mirrors
// ----------------------------------------------------------------------------
//  channel   ports                         transaction
//  request   start, busy, req_*            start high while busy low
//  response  strobe, rsp_*                 strobe high for one cycle
//  config    csr_we, csr_index, csr_wdata  csr_we high
//
//  write: busy stays low; read: result in the cycle after acceptance
//  apply point op: each pixel is read then written on the frame ram
//  apply mirror: each swapped pixel pair is read twice then written twice through the same ram ports
//  synchronous reset clears the sequencer, pending response and config
//  the response cannot be stalled; frame contents are not cleared by reset
// ----------------------------------------------------------------------------
module rgb_frame_effect_engine_unit #(
   parameter int MAX_COLS = rfe_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = rfe_pkg::MAX_ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [rfe_pkg::KIND_W-1:0]      req_kind,
   input  logic [rfe_pkg::COORD_W-1:0]     req_pixel_row,
   input  logic [rfe_pkg::COORD_W-1:0]     req_pixel_col,
   input  logic [rfe_pkg::CH_W-1:0]        req_in_red,
   input  logic [rfe_pkg::CH_W-1:0]        req_in_green,
   input  logic [rfe_pkg::CH_W-1:0]        req_in_blue,
   input  logic [rfe_pkg::CODE_W-1:0]      req_effect_code,
   output logic                            strobe,
   output logic [rfe_pkg::CH_W-1:0]        rsp_out_red,
   output logic [rfe_pkg::CH_W-1:0]        rsp_out_green,
   output logic [rfe_pkg::CH_W-1:0]        rsp_out_blue,
   input  logic                            csr_we,
   input  logic [rfe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rfe_pkg::CFG_W-1:0]       csr_wdata
);
   import rfe_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   function automatic logic [AW-1:0] addr_of(input logic [CFG_W-1:0] r,
                                             input logic [CFG_W-1:0] c);
      return AW'(32'(r) * 32'(MAX_COLS) + 32'(c));
   endfunction

   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  frame_cols_ff, frame_cols_in;
   logic [CFG_W-1:0]  frame_rows_ff, frame_rows_in;
   logic [CFG_W-1:0]  row_ff, row_in;
   logic [CFG_W-1:0]  col_ff, col_in;
   logic [CFG_W-1:0]  row_lim_ff, row_lim_in;
   logic [CFG_W-1:0]  col_lim_ff, col_lim_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic              vflip_ff, vflip_in;
   logic [PIX_W-1:0]  hold_ff, hold_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              inside_ff, inside_in;

   logic [CFG_W-1:0]  eff_rows;
   logic [CFG_W-1:0]  eff_cols;
   logic [CFG_W-1:0]  req_row;
   logic [CFG_W-1:0]  req_col;
   logic              req_inside;
   logic [CFG_W-1:0]  part_row;
   logic [CFG_W-1:0]  part_col;
   logic [AW-1:0]     addr_a;
   logic [AW-1:0]     addr_b;
   logic [CFG_W-1:0]  col_nx;
   logic [CFG_W-1:0]  row_nx;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [PIX_W-1:0]  ram_wr_data;
   logic [AW-1:0]     ram_rd_addr;
   logic [PIX_W-1:0]  ram_rd_data;

   rfe_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign eff_rows = (32'(frame_rows_ff) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : frame_rows_ff;
   assign eff_cols = (32'(frame_cols_ff) > MAX_COLS) ? CFG_W'(MAX_COLS) : frame_cols_ff;
   assign req_row    = {1'b0, req_pixel_row};
   assign req_col    = {1'b0, req_pixel_col};
   assign req_inside = (req_row < eff_rows) && (req_col < eff_cols);

   assign part_row = vflip_ff ? (eff_rows - 7'd1 - row_ff) : row_ff;
   assign part_col = vflip_ff ? col_ff : (eff_cols - 7'd1 - col_ff);
   assign addr_a   = addr_of(row_ff, col_ff);
   assign addr_b   = addr_of(part_row, part_col);
   assign col_nx   = col_ff + 7'd1;
   assign row_nx   = row_ff + 7'd1;

   always_comb begin
      frame_cols_in = frame_cols_ff;
      frame_rows_in = frame_rows_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_FRAME_COLUMNS: frame_cols_in = csr_wdata;
            REG_FRAME_ROWS:    frame_rows_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_pend_ff    <= 1'b0;
         frame_cols_ff <= '0;
         frame_rows_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rd_pend_ff    <= rd_pend_in;
         frame_cols_ff <= frame_cols_in;
         frame_rows_ff <= frame_rows_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff     <= row_in;
      col_ff     <= col_in;
      row_lim_ff <= row_lim_in;
      col_lim_ff <= col_lim_in;
      code_ff    <= code_in;
      vflip_ff   <= vflip_in;
      hold_ff    <= hold_in;
      inside_ff  <= inside_in;
   end

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      row_lim_in  = row_lim_ff;
      col_lim_in  = col_lim_ff;
      code_in     = code_ff;
      vflip_in    = vflip_ff;
      hold_in     = hold_ff;
      inside_in   = inside_ff;
      rd_pend_in  = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_a;
      ram_wr_data = ram_rd_data;
      ram_rd_addr = addr_a;

      unique case (state_ff)
         ST_IDLE: begin
            ram_rd_addr = addr_of(req_row, req_col);
            ram_wr_addr = addr_of(req_row, req_col);
            ram_wr_data = {req_in_red, req_in_green, req_in_blue};
            if (start) begin
               unique case (kind_type'(req_kind))
                  KIND_WRITE: ram_wr_en = req_inside;
                  KIND_READ: begin
                     rd_pend_in = 1'b1;
                     inside_in  = req_inside;
                  end
                  KIND_APPLY: begin
                     row_in   = '0;
                     col_in   = '0;
                     code_in  = req_effect_code;
                     vflip_in = (req_effect_code == EFF_VFLIP);
                     priority if (req_effect_code == EFF_HFLIP) begin
                        row_lim_in = eff_rows;
                        col_lim_in = eff_cols >> 1;
                        if ((eff_rows != '0) && ((eff_cols >> 1) != '0)) begin
                           state_in = ST_SW_RDA;
                        end
                     end else if (req_effect_code == EFF_VFLIP) begin
                        row_lim_in = eff_rows >> 1;
                        col_lim_in = eff_cols;
                        if (((eff_rows >> 1) != '0) && (eff_cols != '0)) begin
                           state_in = ST_SW_RDA;
                        end
                     end else if (req_effect_code <= EFF_CONTRAST) begin
                        row_lim_in = eff_rows;
                        col_lim_in = eff_cols;
                        if ((eff_rows != '0) && (eff_cols != '0)) begin
                           state_in = ST_PT_RD;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_PT_RD: begin
            state_in = ST_PT_WR;
         end
         ST_PT_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = point_op(ram_rd_data, code_ff);
            state_in    = ST_PT_RD;
         end
         ST_SW_RDA: begin
            state_in = ST_SW_RDB;
         end
         ST_SW_RDB: begin
            ram_rd_addr = addr_b;
            hold_in     = ram_rd_data;
            state_in    = ST_SW_WA;
         end
         ST_SW_WA: begin
            ram_wr_en = 1'b1;
            state_in  = ST_SW_WB;
         end
         ST_SW_WB: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = addr_b;
            ram_wr_data = hold_ff;
            state_in    = ST_SW_RDA;
         end
         default: state_in = ST_IDLE;
      endcase

      // advance over the frame after the last write of each pixel or pair
      if ((state_ff == ST_PT_WR) || (state_ff == ST_SW_WB)) begin
         if (col_nx == col_lim_ff) begin
            col_in = '0;
            row_in = row_nx;
            if (row_nx == row_lim_ff) begin
               state_in = ST_IDLE;
            end
         end else begin
            col_in = col_nx;
         end
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign strobe        = rd_pend_ff;
   assign rsp_out_red   = inside_ff ? ram_rd_data[2*CH_W +: CH_W] : '0;
   assign rsp_out_green = inside_ff ? ram_rd_data[CH_W +: CH_W] : '0;
   assign rsp_out_blue  = inside_ff ? ram_rd_data[0 +: CH_W] : '0;

endmodule

>>> src/rfe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfe_checker
// port-level checks of the frame effect engine handshakes
// ----------------------------------------------------------------------------
`include "rgb_frame_effect_engine_unit_defines.svh"

module rfe_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       strobe,
   input logic [rfe_pkg::KIND_W-1:0] req_kind
);
   import rfe_pkg::*;

   `RFE_ASSERT_NEXT(a_read_gives_rsp, clock, reset, start && !busy && req_kind == KIND_READ, strobe)
   `RFE_ASSERT_SAME(a_rsp_from_read, clock, reset, strobe, $past(start && !busy && req_kind == KIND_READ))
   `RFE_ASSERT_SAME(a_no_rsp_while_busy, clock, reset, busy, !strobe)
   `RFE_ASSERT_SAME(a_busy_from_apply, clock, reset, $rose(busy), $past(start && req_kind == KIND_APPLY))

endmodule

bind rgb_frame_effect_engine_unit rfe_checker u_rfe_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .strobe   (strobe),
   .req_kind (req_kind)
);
